// ===== design/rmq_pkg.sv =====
// Shared constants and types for the rotation matrix to quaternion core.
package rmq_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 14;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

endpackage

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Top level: rotation matrix to unit quaternion through a square-root and divider cell chain.
// An item passes the front register, the square-root cells, the divider cells and
// the output register; SW = root bits (16 by default), NW = DATA_WIDTH + FRAC_BITS + 2 (32).
// Throughput is one item per cycle; each root and quotient bit has its own cell.
// The whole chain stalls together while a finished item waits at the output.
// Reset clears only the valid bits of the chain; no item is in flight after reset.
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS,
  localparam int unsigned DW   = DATA_WIDTH,
  localparam int unsigned FB   = FRAC_BITS,
  localparam int unsigned IW   = ((9 * DW + 7) / 8) * 8,
  localparam int unsigned OW   = ((4 * DW + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [IW-1:0] s_axis_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [OW-1:0] m_axis_tdata,  // qw, qx, qy, qz
  output logic [2:0]    m_axis_tuser   // branch, invalid
);

  localparam int unsigned RADW = ((DW > FB + 1) ? DW : FB + 1) + 3;
  localparam int unsigned SW   = (RADW - 1 + FB + 1) / 2;
  localparam int unsigned NP   = 2 * SW;
  localparam int unsigned NW   = DW + FB + 2;
  localparam int unsigned PW   = 3 * (DW + 1) + 3 + 2 + 1;

  logic ce;

  logic               fr_valid;
  logic [NP-1:0]      fr_rad;
  logic [2:0][DW:0]   fr_mag;
  logic [2:0]         fr_neg;
  rmq_pkg::branch_e   fr_branch;
  logic               fr_inval;

  logic               sq_valid [SW+1];
  logic [NP-1:0]      sq_rad   [SW+1];
  logic [SW:0]        sq_rem   [SW+1];
  logic [SW-1:0]      sq_root  [SW+1];
  logic [PW-1:0]      sq_pay   [SW+1];

  logic               dv_valid [NW+1];
  logic [SW-1:0]      dv_root  [NW+1];
  logic [2:0][NW-1:0] dv_num   [NW+1];
  logic [2:0][SW:0]   dv_rem   [NW+1];
  logic [2:0][NW-1:0] dv_quo   [NW+1];
  logic [PW-1:0]      dv_pay   [NW+1];

  logic [2:0][DW:0]   end_mag;
  logic [2:0]         end_neg;
  rmq_pkg::branch_e   end_branch;
  logic               end_inval;
  logic [NW-1:0]      root_c;
  logic [DW-1:0]      l_sat [3];
  logic [DW-1:0]      r_sat;
  logic [DW-1:0]      one_sat;
  logic [DW-1:0]      q_d [4];

  logic               out_valid_q;
  logic [DW-1:0]      q_q [4];
  rmq_pkg::branch_e   branch_q;
  logic               inval_q;

  assign ce            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = ce;

  rmq_front #(
    .DW   (DW),
    .FB   (FB),
    .RADW (RADW),
    .NP   (NP)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ce_i     (ce),
    .valid_i  (s_axis_tvalid),
    .mat_i    (s_axis_tdata[9*DW-1:0]),
    .valid_o  (fr_valid),
    .rad_o    (fr_rad),
    .mag_o    (fr_mag),
    .neg_o    (fr_neg),
    .branch_o (fr_branch),
    .inval_o  (fr_inval)
  );

  assign sq_valid[0] = fr_valid;
  assign sq_rad[0]   = fr_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_pay[0]   = {fr_inval, fr_branch, fr_neg, fr_mag};

  for (genvar c = 0; c < SW; c++) begin : g_sqrt
    rmq_sqrt_cell #(
      .SW (SW),
      .NP (NP),
      .PW (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (sq_valid[c]),
      .rad_i   (sq_rad[c]),
      .rem_i   (sq_rem[c]),
      .root_i  (sq_root[c]),
      .pay_i   (sq_pay[c]),
      .valid_o (sq_valid[c+1]),
      .rad_o   (sq_rad[c+1]),
      .rem_o   (sq_rem[c+1]),
      .root_o  (sq_root[c+1]),
      .pay_o   (sq_pay[c+1])
    );
  end

  always_comb begin
    dv_valid[0] = sq_valid[SW];
    dv_root[0]  = sq_root[SW];
    dv_pay[0]   = sq_pay[SW];
    for (int l = 0; l < 3; l++) begin
      dv_num[0][l] = (NW'(sq_pay[SW][l*(DW+1) +: DW+1]) << FB) + NW'(sq_root[SW]);
      dv_rem[0][l] = '0;
      dv_quo[0][l] = '0;
    end
  end

  for (genvar c = 0; c < NW; c++) begin : g_div
    rmq_div_cell #(
      .SW (SW),
      .NW (NW),
      .PW (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (dv_valid[c]),
      .root_i  (dv_root[c]),
      .num_i   (dv_num[c]),
      .rem_i   (dv_rem[c]),
      .quo_i   (dv_quo[c]),
      .pay_i   (dv_pay[c]),
      .valid_o (dv_valid[c+1]),
      .root_o  (dv_root[c+1]),
      .num_o   (dv_num[c+1]),
      .rem_o   (dv_rem[c+1]),
      .quo_o   (dv_quo[c+1]),
      .pay_o   (dv_pay[c+1])
    );
  end

  function automatic logic [DW-1:0] sat(input logic neg, input logic [NW-1:0] mag);
    logic [NW-1:0] lim;
    lim = NW'(1) << (DW - 1);
    if (!neg) begin
      return (mag >= lim) ? DW'(lim - NW'(1)) : mag[DW-1:0];
    end
    return (mag > lim) ? DW'(lim) : DW'(-mag[DW-1:0]);
  endfunction

  always_comb begin
    end_mag    = dv_pay[NW][3*(DW+1)-1:0];
    end_neg    = dv_pay[NW][3*(DW+1) +: 3];
    end_branch = rmq_pkg::branch_e'(dv_pay[NW][3*(DW+1)+3 +: 2]);
    end_inval  = dv_pay[NW][PW-1];
    root_c  = (NW'(dv_root[NW]) + NW'(1)) >> 1;
    r_sat   = sat(1'b0, root_c);
    one_sat = sat(1'b0, NW'(1) << FB);
    for (int l = 0; l < 3; l++) begin
      l_sat[l] = sat(end_neg[l], dv_quo[NW][l]);
    end
    case (end_branch)
      rmq_pkg::BR_TRACE: begin
        q_d[0] = r_sat;    q_d[1] = l_sat[0]; q_d[2] = l_sat[1]; q_d[3] = l_sat[2];
      end
      rmq_pkg::BR_X: begin
        q_d[0] = l_sat[0]; q_d[1] = r_sat;    q_d[2] = l_sat[1]; q_d[3] = l_sat[2];
      end
      rmq_pkg::BR_Y: begin
        q_d[0] = l_sat[0]; q_d[1] = l_sat[2]; q_d[2] = r_sat;    q_d[3] = l_sat[1];
      end
      default: begin
        q_d[0] = l_sat[0]; q_d[1] = l_sat[1]; q_d[2] = l_sat[2]; q_d[3] = r_sat;
      end
    endcase
    if (end_inval) begin
      q_d[0] = one_sat;
      q_d[1] = '0;
      q_d[2] = '0;
      q_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ce) begin
      out_valid_q <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int p = 0; p < 4; p++) begin
        q_q[p] <= q_d[p];
      end
      branch_q <= end_branch;
      inval_q  <= end_inval;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OW'({q_q[3], q_q[2], q_q[1], q_q[0]});
  assign m_axis_tuser  = {inval_q, branch_q};

`ifndef SYNTHESIS
  a_inval_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && inval_q) |-> (branch_q != rmq_pkg::BR_TRACE))
    else $error("invalid item reported in trace branch");

  a_inval_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && inval_q) |-> (q_q[1] == '0 && q_q[2] == '0 && q_q[3] == '0))
    else $error("invalid item is not the identity");

  a_trace_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && branch_q == rmq_pkg::BR_TRACE) |-> !q_q[0][DW-1])
    else $error("negative scalar part in trace branch");
`endif

endmodule

// ===== design/rmq_front.sv =====
// Front stage: trace test, dominant axis, radicand and off-diagonal terms.
module rmq_front #(
  parameter int unsigned DW   = rmq_pkg::DATA_WIDTH,
  parameter int unsigned FB   = rmq_pkg::FRAC_BITS,
  parameter int unsigned RADW = DW + 3,
  parameter int unsigned NP   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ce_i,
  input  logic                 valid_i,
  input  logic [9*DW-1:0]      mat_i,
  output logic                 valid_o,
  output logic [NP-1:0]        rad_o,
  output logic [2:0][DW:0]     mag_o,
  output logic [2:0]           neg_o,
  output rmq_pkg::branch_e     branch_o,
  output logic                 inval_o
);

  logic signed [DW-1:0]   m [9];
  logic signed [RADW-1:0] one_c;
  logic signed [RADW-1:0] trace;
  logic signed [RADW-1:0] rad;
  logic signed [DW:0]     lane [3];
  logic [1:0]             axis;
  rmq_pkg::branch_e       branch;
  logic                   rad_pos;
  logic                   valid_q;
  logic [NP-1:0]          rad_q;
  logic [2:0][DW:0]       mag_q;
  logic [2:0]             neg_q;
  rmq_pkg::branch_e       branch_q;
  logic                   inval_q;

  assign one_c = RADW'(1) << FB;

  function automatic logic signed [RADW-1:0] ext(input logic signed [DW-1:0] v);
    return RADW'(v);
  endfunction

  function automatic logic signed [DW:0] add(input logic signed [DW-1:0] a,
                                             input logic signed [DW-1:0] b);
    return (DW+1)'(a) + (DW+1)'(b);
  endfunction

  function automatic logic signed [DW:0] sub(input logic signed [DW-1:0] a,
                                             input logic signed [DW-1:0] b);
    return (DW+1)'(a) - (DW+1)'(b);
  endfunction

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      m[e] = mat_i[e*DW +: DW];
    end
    trace = ext(m[0]) + ext(m[4]) + ext(m[8]);
    axis = 2'd0;
    if (m[4] > m[0]) begin
      axis = 2'd1;
    end
    if ((axis == 2'd0 && m[8] > m[0]) || (axis == 2'd1 && m[8] > m[4])) begin
      axis = 2'd2;
    end
    if (trace > 0) begin
      branch  = rmq_pkg::BR_TRACE;
      rad     = trace + one_c;
      lane[0] = sub(m[7], m[5]);
      lane[1] = sub(m[2], m[6]);
      lane[2] = sub(m[3], m[1]);
    end else begin
      case (axis)
        2'd0: begin
          branch  = rmq_pkg::BR_X;
          rad     = ext(m[0]) - ext(m[4]) - ext(m[8]) + one_c;
          lane[0] = sub(m[7], m[5]);
          lane[1] = add(m[3], m[1]);
          lane[2] = add(m[6], m[2]);
        end
        2'd1: begin
          branch  = rmq_pkg::BR_Y;
          rad     = ext(m[4]) - ext(m[8]) - ext(m[0]) + one_c;
          lane[0] = sub(m[2], m[6]);
          lane[1] = add(m[7], m[5]);
          lane[2] = add(m[1], m[3]);
        end
        default: begin
          branch  = rmq_pkg::BR_Z;
          rad     = ext(m[8]) - ext(m[0]) - ext(m[4]) + one_c;
          lane[0] = sub(m[3], m[1]);
          lane[1] = add(m[2], m[6]);
          lane[2] = add(m[5], m[7]);
        end
      endcase
    end
    rad_pos = (rad > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rad_q    <= rad_pos ? (NP'(rad[RADW-2:0]) << FB) : '0;
      inval_q  <= !rad_pos;
      branch_q <= branch;
      for (int l = 0; l < 3; l++) begin
        neg_q[l] <= lane[l][DW];
        mag_q[l] <= lane[l][DW] ? (DW+1)'(-(DW+2)'(lane[l])) : lane[l];
      end
    end
  end

  assign valid_o  = valid_q;
  assign rad_o    = rad_q;
  assign mag_o    = mag_q;
  assign neg_o    = neg_q;
  assign branch_o = branch_q;
  assign inval_o  = inval_q;

endmodule

// ===== design/rmq_sqrt_cell.sv =====
// One square-root cell: settles one root bit from two radicand bits.
module rmq_sqrt_cell #(
  parameter int unsigned SW = 16,
  parameter int unsigned NP = 32,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ce_i,
  input  logic          valid_i,
  input  logic [NP-1:0] rad_i,
  input  logic [SW:0]   rem_i,
  input  logic [SW-1:0] root_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NP-1:0] rad_o,
  output logic [SW:0]   rem_o,
  output logic [SW-1:0] root_o,
  output logic [PW-1:0] pay_o
);

  logic [SW+2:0] rem_x;
  logic [SW+2:0] trial;
  logic          take;
  logic          valid_q;
  logic [NP-1:0] rad_q;
  logic [SW:0]   rem_q;
  logic [SW-1:0] root_q;
  logic [PW-1:0] pay_q;

  assign rem_x = {rem_i, rad_i[NP-1 -: 2]};
  assign trial = (SW+3)'({root_i, 2'b01});
  assign take  = (rem_x >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= take ? (SW+1)'(rem_x - trial) : rem_x[SW:0];
      root_q <= {root_i[SW-2:0], take};
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

// ===== design/rmq_div_cell.sv =====
// One divider cell: settles one quotient bit in each of the three lanes.
module rmq_div_cell #(
  parameter int unsigned SW = 16,
  parameter int unsigned NW = 32,
  parameter int unsigned PW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ce_i,
  input  logic               valid_i,
  input  logic [SW-1:0]      root_i,
  input  logic [2:0][NW-1:0] num_i,
  input  logic [2:0][SW:0]   rem_i,
  input  logic [2:0][NW-1:0] quo_i,
  input  logic [PW-1:0]      pay_i,
  output logic               valid_o,
  output logic [SW-1:0]      root_o,
  output logic [2:0][NW-1:0] num_o,
  output logic [2:0][SW:0]   rem_o,
  output logic [2:0][NW-1:0] quo_o,
  output logic [PW-1:0]      pay_o
);

  logic [SW+1:0]      dvs;
  logic [SW+1:0]      rem_x [3];
  logic [2:0]         take;
  logic               valid_q;
  logic [SW-1:0]      root_q;
  logic [2:0][NW-1:0] num_q;
  logic [2:0][SW:0]   rem_q;
  logic [2:0][NW-1:0] quo_q;
  logic [PW-1:0]      pay_q;

  assign dvs = (SW+2)'({root_i, 1'b0});

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_x[l] = {rem_i[l], num_i[l][NW-1]};
      take[l]  = (rem_x[l] >= dvs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      root_q <= root_i;
      pay_q  <= pay_i;
      for (int l = 0; l < 3; l++) begin
        num_q[l] <= num_i[l] << 1;
        rem_q[l] <= take[l] ? (SW+1)'(rem_x[l] - dvs) : rem_x[l][SW:0];
        quo_q[l] <= {quo_i[l][NW-2:0], take[l]};
      end
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign pay_o   = pay_q;

endmodule

// ===== bench/rotation_matrix_to_quaternion_core_tb.sv =====
// Testbench for the rotation matrix to quaternion core against a behavioral predictor.
module rotation_matrix_to_quaternion_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = 144;
  localparam int OW = 64;
  localparam int LATENCY = 50;

  typedef logic signed [rmq_pkg::DATA_WIDTH-1:0] elem_t;
  typedef struct packed {
    logic [rmq_pkg::DATA_WIDTH-1:0] qw, qx, qy, qz;
    rmq_pkg::branch_e branch;
    logic invalid;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  quat_t expected_quats[$];
  int errors = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 31;
  int hold_cycles = 0;

  rotation_matrix_to_quaternion_core uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint half_ratio(longint d, longint unsigned s);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : d;
    q = ((mag << rmq_pkg::FRAC_BITS) + s) / (2 * s);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [rmq_pkg::DATA_WIDTH-1:0] clamp(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[rmq_pkg::DATA_WIDTH-1:0];
  endfunction

  function automatic quat_t predict_quat(logic [IW-1:0] data);
    longint m[3][3];
    longint q[4];
    longint one, tr, rad;
    longint unsigned s;
    int i, j, k;
    quat_t res;
    one = 64'sd1 << rmq_pkg::FRAC_BITS;
    for (int n = 0; n < 9; n++) m[n / 3][n % 3] = elem_t'(data[n*16 +: 16]);
    q = '{0, 0, 0, 0};
    res.invalid = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      res.branch = rmq_pkg::BR_TRACE;
      s = int_sqrt(longint'(tr + one) << rmq_pkg::FRAC_BITS);
      q[0] = (s + 1) >> 1;
      q[1] = half_ratio(m[2][1] - m[1][2], s);
      q[2] = half_ratio(m[0][2] - m[2][0], s);
      q[3] = half_ratio(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      res.branch = rmq_pkg::branch_e'(i + 1);
      rad = m[i][i] - m[j][j] - m[k][k] + one;
      s = (rad > 0) ? int_sqrt(rad << rmq_pkg::FRAC_BITS) : 0;
      if (s == 0) begin
        res.invalid = 1'b1;
        q[0] = one;
      end else begin
        q[1 + i] = (s + 1) >> 1;
        q[0] = half_ratio(m[k][j] - m[j][k], s);
        q[1 + j] = half_ratio(m[j][i] + m[i][j], s);
        q[1 + k] = half_ratio(m[k][i] + m[i][k], s);
      end
    end
    res.qw = clamp(q[0]);
    res.qx = clamp(q[1]);
    res.qy = clamp(q[2]);
    res.qz = clamp(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_quats.push_back(predict_quat(s_axis_tdata));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata[15:0], 0);
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (m_axis_tdata[15:0] != e.qw)
          report_mismatch("qw", elem_t'(m_axis_tdata[15:0]), elem_t'(e.qw));
        if (m_axis_tdata[31:16] != e.qx)
          report_mismatch("qx", elem_t'(m_axis_tdata[31:16]), elem_t'(e.qx));
        if (m_axis_tdata[47:32] != e.qy)
          report_mismatch("qy", elem_t'(m_axis_tdata[47:32]), elem_t'(e.qy));
        if (m_axis_tdata[63:48] != e.qz)
          report_mismatch("qz", elem_t'(m_axis_tdata[63:48]), elem_t'(e.qz));
        if (m_axis_tuser[1:0] != e.branch)
          report_mismatch("branch", m_axis_tuser[1:0], e.branch);
        if (m_axis_tuser[2] != e.invalid)
          report_mismatch("invalid", m_axis_tuser[2], e.invalid);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_matrix(logic [IW-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic finish_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_quats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [IW-1:0] pack9(longint a[9]);
    logic [IW-1:0] d;
    for (int n = 0; n < 9; n++) d[n*16 +: 16] = a[n][15:0];
    return d;
  endfunction

  function automatic longint rand_elem();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(32768) - 16384;
      2: return ($urandom_range(1) ? 32767 : -32768);
      default: return $urandom_range(400) - 200;
    endcase
  endfunction

  // A near-rotation matrix: a signed axis permutation with small noise.
  function automatic logic [IW-1:0] rand_rotation();
    longint a[9];
    int perm[3];
    int p;
    perm = '{0, 1, 2};
    p = $urandom_range(5);
    if (p & 1) perm = '{perm[1], perm[0], perm[2]};
    if (p >= 2) perm = '{perm[2], perm[0], perm[1]};
    if (p >= 4) perm = '{perm[1], perm[2], perm[0]};
    for (int n = 0; n < 9; n++) a[n] = $urandom_range(6000) - 3000;
    for (int r = 0; r < 3; r++)
      a[r*3 + perm[r]] = ($urandom_range(1) ? 1 : -1) * (16384 - $urandom_range(4000));
    return pack9(a);
  endfunction

  task automatic test_directed();
    longint id[9];
    longint a[9];
    id = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    send_matrix(pack9(id));
    a = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    send_matrix(pack9(a));
    a = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    send_matrix(pack9(a));
    a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    send_matrix(pack9(a));
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(pack9(a));
    a = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
    send_matrix(pack9(a));
    a = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_matrix(pack9(a));
    a = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(pack9(a));
    a = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
    send_matrix(pack9(a));
    a = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, -1};
    send_matrix(pack9(a));
    a = '{-16384, 32767, 32767, 32767, -16384, 32767, 32767, 32767, -16384};
    send_matrix(pack9(a));
    a = '{-100, 0, 0, 0, -100, 0, 0, 0, -100};
    send_matrix(pack9(a));
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 1};
    send_matrix(pack9(a));
    a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    a[1] = 20000;
    a[3] = -20000;
    send_matrix(pack9(a));
    a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(pack9(a));
    a = '{-1, 5, 9, 7, -1, 3, 2, 4, 0};
    send_matrix(pack9(a));
    finish_sending();
  endtask

  task automatic test_random(int count, int idle_pct);
    longint a[9];
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    repeat (count) begin
      if ($urandom_range(99) < 70) begin
        send_matrix(rand_rotation());
      end else begin
        for (int n = 0; n < 9; n++) a[n] = rand_elem();
        send_matrix(pack9(a));
      end
    end
    finish_sending();
  endtask

  task automatic test_backpressure();
    hold_cycles <= 300;
    @(posedge clk_i);
    test_random(150, 0);
    send_idle_pct = 31;
    recv_idle_pct = 31;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(800, 31);
    drain();
    test_backpressure();
    test_random(400, 0);
    test_random(600, 31);
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt_cell.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion_core.sv
bench/rotation_matrix_to_quaternion_core_tb.sv
